@@ rtl/pht_pkg.sv @@
// Pointer handle table: shared package.
// Holds operation and status codes, controller states and the command and
// status structs between controller and datapath. No dependencies.
package pht_pkg;

   typedef enum logic [2:0] {
      KIND_LOOKUP   = 3'd0,
      KIND_REGISTER = 3'd1,
      KIND_BIND     = 3'd2,
      KIND_FETCH    = 3'd3,
      KIND_CLEAR    = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_NOT_FOUND  = 3'd1,
      STATUS_FULL       = 3'd2,
      STATUS_IN_USE     = 3'd3,
      STATUS_BAD_HANDLE = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_INIT_SWEEP,
      ST_IDLE,
      ST_DISPATCH,
      ST_WALK_START,
      ST_WALK,
      ST_BIND_CHK,
      ST_FETCH_CHK,
      ST_CLR_SWEEP
   } state_type;

   // Which result the datapath loads into the response register.
   typedef enum logic [3:0] {
      RES_OK,
      RES_FOUND,
      RES_NOT_FOUND,
      RES_FULL,
      RES_APPEND,
      RES_BIND,
      RES_IN_USE,
      RES_BAD,
      RES_FETCH
   } res_sel_type;

   // Write address and data source for the entry store.
   typedef enum logic [1:0] {
      WR_ZERO,
      WR_APPEND,
      WR_BIND
   } wr_sel_type;

   typedef struct packed {
      logic        load;
      logic        idx_clr;
      logic        walk_issue;
      logic        sweep_step;
      logic        rd_hdl;
      logic        wr_en;
      wr_sel_type  wr_sel;
      logic        fill_inc;
      logic        fill_set0;
      logic        res_load;
      res_sel_type res_sel;
   } cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       hit;
      logic       walk_end;
      logic       full;
      logic       hbad;
      logic       slot_zero;
      logic       slot_same;
      logic       sweep_last;
      logic       rsp_busy;
   } sts_type;

endpackage

@@ rtl/pht_ram.sv @@
// Pointer handle table: entry store.
// One write port and one read port with registered read data.
// Depends on nothing.
module pht_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/pht_dp.sv @@
// Pointer handle table: datapath.
// Request capture, size register, fill count, walk counter, compare and
// response register. Depends on pht_pkg and pht_ram.
module pht_dp #(
   parameter int DEPTH     = 1024,
   parameter int PTR_WIDTH = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [2:0]      req_kind,
   input  logic [63:0]     req_pointer_in,
   input  logic [9:0]      req_handle_in,
   input  logic            csr_wr_en,
   input  logic [10:0]     csr_wr_data,
   input  logic            rsp_ready,
   output logic            rsp_valid,
   output logic [2:0]      rsp_status,
   output logic [9:0]      rsp_handle_out,
   output logic [63:0]     rsp_pointer_out,
   input  pht_pkg::cmd_type cmd,
   output pht_pkg::sts_type sts
);
   import pht_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = (CW > 11) ? CW : 11;

   logic [2:0]           kind_ff, kind_in;
   logic [PTR_WIDTH-1:0] ptr_ff, ptr_in;
   logic [9:0]           hdl_ff, hdl_in;
   logic [10:0]          size_ff, size_in;
   logic [CW-1:0]        fill_ff, fill_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        cmp_idx_ff, cmp_idx_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           rsp_status_ff, rsp_status_in;
   logic [9:0]           rsp_handle_ff, rsp_handle_in;
   logic [63:0]          rsp_pointer_ff, rsp_pointer_in;

   logic [SW-1:0]        eff_size, size_ext, depth_ext, fill_ext, hdl_ext;
   logic [AW+9:0]        hdl_wide;
   logic [CW+9:0]        cmp_wide, fill_wide;
   logic [AW-1:0]        hdl_addr, rd_addr, wr_addr;
   logic [PTR_WIDTH-1:0] wr_data, rd_data;
   logic                 idx_below_fill;

   pht_ram #(.DEPTH(DEPTH), .WIDTH(PTR_WIDTH)) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      size_ext  = SW'(size_ff);
      depth_ext = SW'(DEPTH);
      eff_size  = (size_ext > depth_ext) ? depth_ext : size_ext;
      fill_ext  = SW'(fill_ff);
      hdl_ext   = SW'(hdl_ff);
      hdl_wide  = (AW + 10)'(hdl_ff);
      hdl_addr  = hdl_wide[AW-1:0];
      cmp_wide  = (CW + 10)'(cmp_idx_ff);
      fill_wide = (CW + 10)'(fill_ff);
      idx_below_fill = idx_ff < fill_ff;
   end

   assign rd_addr = cmd.rd_hdl ? hdl_addr : idx_ff[AW-1:0];

   always_comb begin
      case (cmd.wr_sel)
         WR_APPEND: begin
            wr_addr = fill_ff[AW-1:0];
            wr_data = ptr_ff;
         end
         WR_BIND: begin
            wr_addr = hdl_addr;
            wr_data = ptr_ff;
         end
         default: begin
            wr_addr = idx_ff[AW-1:0];
            wr_data = '0;
         end
      endcase
   end

   always_comb begin
      kind_in    = cmd.load ? req_kind : kind_ff;
      ptr_in     = cmd.load ? req_pointer_in[PTR_WIDTH-1:0] : ptr_ff;
      hdl_in     = cmd.load ? req_handle_in : hdl_ff;
      size_in    = csr_wr_en ? csr_wr_data : size_ff;
      cmp_idx_in = idx_ff;
      cmp_vld_in = cmd.walk_issue && idx_below_fill;

      fill_in = fill_ff;
      if (cmd.fill_set0) begin
         fill_in = '0;
      end else if (cmd.fill_inc) begin
         fill_in = fill_ff + CW'(1);
      end

      // Walk stops advancing at the fill count; sweep runs over every entry.
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.sweep_step || (cmd.walk_issue && idx_below_fill)) begin
         idx_in = idx_ff + CW'(1);
      end
   end

   always_comb begin
      rsp_status_in  = STATUS_OK;
      rsp_handle_in  = '0;
      rsp_pointer_in = '0;
      case (cmd.res_sel)
         RES_FOUND:     rsp_handle_in = cmp_wide[9:0];
         RES_NOT_FOUND: rsp_status_in = STATUS_NOT_FOUND;
         RES_FULL:      rsp_status_in = STATUS_FULL;
         RES_APPEND:    rsp_handle_in = fill_wide[9:0];
         RES_BIND:      rsp_handle_in = hdl_ff;
         RES_IN_USE:    rsp_status_in = STATUS_IN_USE;
         RES_BAD:       rsp_status_in = STATUS_BAD_HANDLE;
         RES_FETCH:     rsp_pointer_in = 64'(rd_data);
         default: begin
            rsp_status_in = STATUS_OK;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (cmd.res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= 11'd1024;
         fill_ff      <= CW'(1);
         idx_ff       <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         size_ff      <= size_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      ptr_ff     <= ptr_in;
      hdl_ff     <= hdl_in;
      cmp_idx_ff <= cmp_idx_in;
      if (cmd.res_load) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_handle_ff  <= rsp_handle_in;
         rsp_pointer_ff <= rsp_pointer_in;
      end
   end

   always_comb begin
      sts.kind       = kind_ff;
      sts.hit        = cmp_vld_ff && (rd_data == ptr_ff);
      sts.walk_end   = !cmp_vld_ff;
      sts.full       = fill_ext >= eff_size;
      sts.hbad       = hdl_ext >= eff_size;
      sts.slot_zero  = rd_data == '0;
      sts.slot_same  = rd_data == ptr_ff;
      sts.sweep_last = idx_ff == CW'(DEPTH - 1);
      sts.rsp_busy   = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_handle_out  = rsp_handle_ff;
   assign rsp_pointer_out = rsp_pointer_ff;

endmodule

@@ rtl/pht_ctrl.sv @@
// Pointer handle table: controller state machine.
// Sequences sweeps, walks, bind and fetch checks through commands to the
// datapath. Depends on pht_pkg.
module pht_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pht_pkg::sts_type sts,
   output pht_pkg::cmd_type cmd
);
   import pht_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT_SWEEP: begin
            if (sts.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (!sts.rsp_busy) begin
               case (sts.kind)
                  KIND_LOOKUP, KIND_REGISTER: state_in = ST_WALK_START;
                  KIND_BIND:  state_in = sts.hbad ? ST_IDLE : ST_BIND_CHK;
                  KIND_FETCH: state_in = sts.hbad ? ST_IDLE : ST_FETCH_CHK;
                  KIND_CLEAR: state_in = ST_CLR_SWEEP;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_WALK_START: state_in = ST_WALK;
         ST_WALK: begin
            if (sts.hit || sts.walk_end) state_in = ST_IDLE;
         end
         ST_BIND_CHK:  state_in = ST_IDLE;
         ST_FETCH_CHK: state_in = ST_IDLE;
         ST_CLR_SWEEP: begin
            if (sts.sweep_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_INIT_SWEEP: begin
            cmd.sweep_step = 1'b1;
            cmd.wr_en      = 1'b1;
            cmd.wr_sel     = WR_ZERO;
         end
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.load    = req_valid;
            cmd.idx_clr = 1'b1;
         end
         ST_DISPATCH: begin
            // Point the read at the handle so bind and fetch see it next cycle.
            cmd.rd_hdl = 1'b1;
            if (!sts.rsp_busy) begin
               case (sts.kind)
                  KIND_LOOKUP, KIND_REGISTER, KIND_CLEAR: begin
                     cmd.res_load = 1'b0;
                  end
                  KIND_BIND, KIND_FETCH: begin
                     cmd.res_load = sts.hbad;
                     cmd.res_sel  = RES_BAD;
                  end
                  default: begin
                     cmd.res_load = 1'b1;
                     cmd.res_sel  = RES_OK;
                  end
               endcase
            end
         end
         ST_WALK_START: begin
            cmd.walk_issue = 1'b1;
         end
         ST_WALK: begin
            cmd.walk_issue = 1'b1;
            if (sts.hit) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_FOUND;
            end else if (sts.walk_end) begin
               cmd.res_load = 1'b1;
               if (sts.kind != KIND_REGISTER) begin
                  cmd.res_sel = RES_NOT_FOUND;
               end else if (sts.full) begin
                  cmd.res_sel = RES_FULL;
               end else begin
                  // Append at the fill count.
                  cmd.res_sel  = RES_APPEND;
                  cmd.wr_en    = 1'b1;
                  cmd.wr_sel   = WR_APPEND;
                  cmd.fill_inc = 1'b1;
               end
            end
         end
         ST_BIND_CHK: begin
            cmd.rd_hdl   = 1'b1;
            cmd.res_load = 1'b1;
            if (sts.slot_zero) begin
               cmd.res_sel = RES_BIND;
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = WR_BIND;
            end else if (sts.slot_same) begin
               cmd.res_sel = RES_BIND;
            end else begin
               cmd.res_sel = RES_IN_USE;
            end
         end
         ST_FETCH_CHK: begin
            cmd.rd_hdl   = 1'b1;
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_FETCH;
         end
         ST_CLR_SWEEP: begin
            cmd.sweep_step = 1'b1;
            cmd.wr_en      = 1'b1;
            cmd.wr_sel     = WR_ZERO;
            if (sts.sweep_last) begin
               cmd.fill_set0 = 1'b1;
               cmd.res_load  = 1'b1;
               cmd.res_sel   = RES_OK;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ rtl/pointer_handle_table_top.sv @@
// Pointer handle table: top level.
// Joins the controller and the datapath. Depends on pht_pkg, pht_ctrl, pht_dp.
//
//  port group  direction  handshake              payload
//  req_        in         req_valid / req_ready  req_kind, req_pointer_in, req_handle_in
//  rsp_        out        rsp_valid / rsp_ready  rsp_status, rsp_handle_out, rsp_pointer_out
//  csr_        in         csr_wr_en              csr_wr_data (table size)
//
// One request at a time. In lookup and register the walk reads one entry per
// cycle through the single store read port. After reset a sweep zeroes the
// store; req_ready stays low. A request is taken while a result waits; its
// work starts once the response register has drained.
module pointer_handle_table_top #(
   parameter int DEPTH     = 1024,
   parameter int PTR_WIDTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [63:0] req_pointer_in,
   input  logic [9:0]  req_handle_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [9:0]  rsp_handle_out,
   output logic [63:0] rsp_pointer_out,
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data
);
   import pht_pkg::*;

   cmd_type cmd;
   sts_type sts;

   pht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pht_dp #(.DEPTH(DEPTH), .PTR_WIDTH(PTR_WIDTH)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_kind        (req_kind),
      .req_pointer_in  (req_pointer_in),
      .req_handle_in   (req_handle_in),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_handle_out  (rsp_handle_out),
      .rsp_pointer_out (rsp_pointer_out),
      .cmd             (cmd),
      .sts             (sts)
   );

   // A result is never loaded over one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.res_load |-> !sts.rsp_busy)
      else $error("response register overwritten");

   // A transfer in never produces a result in the following cycle.
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // Appends stay below the effective table size.
   a_append_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_inc |-> !sts.full)
      else $error("append beyond table size");

   // Bind writes only an empty slot within range.
   a_bind_write: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_en && cmd.wr_sel == WR_BIND) |-> (!sts.hbad && sts.slot_zero))
      else $error("bind wrote an occupied or bad slot");

endmodule
